@@ rtl/core/cprd_pkg.sv @@
// ---------------------------------------------------------------------------
// cprd_pkg
// Shared constants, register indexes and control types of the coherent pulse
// run detector.
// ---------------------------------------------------------------------------
`default_nettype none

package cprd_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int DUR_W       = 16;
  localparam int CNT_W       = 10;
  localparam int SLOTS       = 2 * NUM_CLASSES;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int K_W         = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int NUM_W       = DUR_W + CNT_W + 1;
  localparam int DEN_W       = CNT_W + 1;

  localparam int REG_IDX_W   = 3;
  localparam int ADDR_W      = REG_IDX_W + 2;
  localparam int DATA_W      = 32;

  localparam logic [REG_IDX_W-1:0] REG_MIN_DURATION      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DURATION      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_RUN_LENGTH    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_CLASS_COUNT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_SIGNAL_LENGTH = 3'd4;

  localparam logic [DUR_W-1:0] RST_MIN_DURATION      = 16'd30;
  localparam logic [DUR_W-1:0] RST_MAX_DURATION      = 16'd4000;
  localparam logic [CNT_W-1:0] RST_MAX_RUN_LENGTH    = 10'd500;
  localparam logic [CNT_W-1:0] RST_MIN_CLASS_COUNT   = 10'd3;
  localparam logic [CNT_W-1:0] RST_MIN_SIGNAL_LENGTH = 10'd13;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [DUR_W-1:0] min_duration;
    logic [DUR_W-1:0] max_duration;
    logic [CNT_W-1:0] max_run_length;
    logic [CNT_W-1:0] min_class_count;
    logic [CNT_W-1:0] min_signal_length;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic stop;
    logic k_inc;
    logic open_slot;
    logic mul;
    logic div_start;
    logic div_write;
    logic est_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic stopped;
    logic pre_fail;
    logic slot_empty;
    logic slot_match;
    logic k_last;
    logic div_done;
    logic est_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/cprd_div.sv @@
// ---------------------------------------------------------------------------
// cprd_div
// Restoring divider producing one quotient bit per cycle for the running
// class average update.
// ---------------------------------------------------------------------------
`default_nettype none

module cprd_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [cprd_pkg::NUM_W-1:0]  dividend,
  input  wire logic [cprd_pkg::DEN_W-1:0]  divisor,
  output logic                             done,
  output logic [cprd_pkg::NUM_W-1:0]       quotient
);
  import cprd_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [DEN_W:0]    rem_shift;
  logic              fits;

  assign rem_shift = {rem, quotient[NUM_W-1]};
  assign fits      = rem_shift >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DEN_W'(rem_shift - {1'b0, den});
      end else begin
        rem <= DEN_W'(rem_shift);
      end
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cprd_dp.sv @@
// ---------------------------------------------------------------------------
// cprd_dp
// Datapath: class storage, run counters, match logic, average update,
// short-pulse estimate sweep and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module cprd_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cprd_pkg::cfg_t              cfg,
  input  wire cprd_pkg::cmd_t              cmd,
  output cprd_pkg::sts_t                   sts,
  input  wire logic                        start_run,
  input  wire logic                        pulse_level,
  input  wire logic [cprd_pkg::DUR_W-1:0]  pulse_duration,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic                             accepted,
  output logic                             run_ended,
  output logic [cprd_pkg::CNT_W-1:0]       run_length,
  output logic                             long_enough,
  output logic [cprd_pkg::DUR_W-1:0]       short_pulse_duration
);
  import cprd_pkg::*;

  logic [DUR_W-1:0]  avg_q [SLOTS];
  logic [CNT_W-1:0]  mem_q [SLOTS];
  logic [CNT_W-1:0]  count;
  logic              stopped;
  logic              took;
  logic              lvl;
  logic [DUR_W-1:0]  dur;
  logic [K_W-1:0]    k;
  logic [SLOT_W-1:0] est_idx;
  logic [DUR_W-1:0]  best0;
  logic [DUR_W-1:0]  best1;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic              div_done;
  logic [NUM_W-1:0]  quo;

  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] rd_idx;
  logic [DUR_W-1:0]  rd_avg;
  logic [CNT_W-1:0]  rd_n;
  logic [DUR_W-1:0]  diff;
  logic [CNT_W-1:0]  count_inc;
  logic              est_hi;
  logic [DUR_W-1:0]  best_cur;
  logic              est_take;
  logic [DUR_W-1:0]  fill0;
  logic [DUR_W-1:0]  fill1;
  logic [DUR_W:0]    best_sum;

  assign cur_slot = SLOT_W'(lvl) * SLOT_W'(NUM_CLASSES) + SLOT_W'(k);
  assign rd_idx   = cmd.est_step ? est_idx : cur_slot;
  assign rd_avg   = avg_q[rd_idx];
  assign rd_n     = mem_q[rd_idx];
  assign diff     = (dur > rd_avg) ? dur - rd_avg : rd_avg - dur;
  assign count_inc = count + 1'b1;

  assign est_hi   = est_idx >= SLOT_W'(NUM_CLASSES);
  assign best_cur = est_hi ? best1 : best0;
  assign est_take = (rd_avg != '0) && (rd_n >= cfg.min_class_count) &&
                    ((best_cur == '0) || (best_cur > rd_avg));

  assign fill0    = (best0 == '0) ? best1 : best0;
  assign fill1    = (best1 == '0) ? best0 : best1;
  assign best_sum = {1'b0, fill0} + {1'b0, fill1};

  assign sts.stopped    = stopped;
  assign sts.pre_fail   = (count >= cfg.max_run_length) || (dur < cfg.min_duration) ||
                          (dur > cfg.max_duration);
  assign sts.slot_empty = rd_n == '0;
  assign sts.slot_match = diff < (rd_avg >> 3);
  assign sts.k_last     = k == K_W'(NUM_CLASSES - 1);
  assign sts.div_done   = div_done;
  assign sts.est_last   = est_idx == SLOT_W'(SLOTS - 1);
  assign sts.out_free   = !result_valid || !result_stall;

  cprd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (num),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        avg_q[i] <= '0;
        mem_q[i] <= '0;
      end
      count   <= '0;
      stopped <= 1'b0;
    end else begin
      if (cmd.load && start_run) begin
        for (int i = 0; i < SLOTS; i++) begin
          avg_q[i] <= '0;
          mem_q[i] <= '0;
        end
        count   <= '0;
        stopped <= 1'b0;
      end
      if (cmd.stop) begin
        stopped <= 1'b1;
      end
      if (cmd.open_slot) begin
        avg_q[cur_slot] <= dur;
        mem_q[cur_slot] <= CNT_W'(1);
      end
      if (cmd.div_write) begin
        avg_q[cur_slot] <= quo[DUR_W-1:0];
        mem_q[cur_slot] <= (rd_n == CNT_MAX) ? CNT_MAX : rd_n + 1'b1;
      end
      if (cmd.open_slot || cmd.div_write) begin
        count <= count_inc;
        if (count_inc >= cfg.max_run_length) begin
          stopped <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      took    <= 1'b0;
      k       <= '0;
      est_idx <= '0;
    end else begin
      if (cmd.load) begin
        took    <= 1'b0;
        k       <= '0;
        est_idx <= '0;
      end
      if (cmd.k_inc) begin
        k <= k + 1'b1;
      end
      if (cmd.open_slot || cmd.div_write) begin
        took <= 1'b1;
      end
      if (cmd.est_step) begin
        est_idx <= est_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lvl   <= pulse_level;
      dur   <= pulse_duration;
      best0 <= '0;
      best1 <= '0;
    end
    if (cmd.mul) begin
      num <= NUM_W'(rd_avg) * NUM_W'(rd_n) + NUM_W'(dur);
      den <= DEN_W'(rd_n) + 1'b1;
    end
    if (cmd.est_step && est_take) begin
      if (est_hi) begin
        best1 <= rd_avg;
      end else begin
        best0 <= rd_avg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      accepted             <= took;
      run_ended            <= stopped;
      run_length           <= count;
      long_enough          <= count > cfg.min_signal_length;
      short_pulse_duration <= best_sum[DUR_W:1];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cprd_ctrl.sv @@
// ---------------------------------------------------------------------------
// cprd_ctrl
// Sequencer for one pulse: run checks, class scan, average update,
// estimate sweep and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module cprd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pulse_valid,
  output logic                 pulse_stall,
  input  wire cprd_pkg::sts_t  sts,
  output cprd_pkg::cmd_t       cmd
);
  import cprd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXAM = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIVS = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_EST  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign pulse_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (pulse_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXAM;
        end
      end
      S_EXAM: begin
        if (sts.stopped) begin
          state_next = S_EST;
        end else if (sts.pre_fail) begin
          cmd.stop   = 1'b1;
          state_next = S_EST;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.slot_empty) begin
          cmd.open_slot = 1'b1;
          state_next    = S_EST;
        end else if (sts.slot_match) begin
          state_next = S_MUL;
        end else if (sts.k_last) begin
          cmd.stop   = 1'b1;
          state_next = S_EST;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_write = 1'b1;
          state_next    = S_EST;
        end
      end
      S_EST: begin
        cmd.est_step = 1'b1;
        if (sts.est_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/coherent_pulse_run_detector.sv @@
// ---------------------------------------------------------------------------
// coherent_pulse_run_detector
// Groups radio pulses into a run of coherent pulses by duration class and
// reports acceptance, run state and a short-pulse estimate for every pulse.
// ---------------------------------------------------------------------------
// Pulses enter on the pulse channel (pulse_valid, pulse_stall) with
// start_run, pulse_level and pulse_duration. Each pulse gives exactly one
// result on the result channel (result_valid, result_stall).
// Limits and the estimate threshold sit in five registers on the APB port;
// they should be written only while no request is in flight.
// One pulse is handled at a time. An ignored pulse, or one that fails a
// duration or run length check, goes from the checks on to the estimate
// sweep; one that opens a class or finds no place scans the classes, and one
// that joins a class also waits for the 27-step serial divider that updates
// the class average. The six-slot estimate sweep follows for every pulse.
// The next pulse is accepted in the cycle after the result is loaded.
// The next pulse is taken once the result is loaded, even if the receiver
// still stalls it; a stalled result holds, and the block then waits with the
// following result until the register frees up.
// Reset clears all classes, the run count and the stop flag, and loads the
// default register values.
// ---------------------------------------------------------------------------
`default_nettype none

module coherent_pulse_run_detector (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cprd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [cprd_pkg::DATA_W-1:0]  pwdata,
  output logic      [cprd_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         pulse_valid,
  output logic                              pulse_stall,
  input  wire logic                         start_run,
  input  wire logic                         pulse_level,
  input  wire logic [cprd_pkg::DUR_W-1:0]   pulse_duration,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic                              accepted,
  output logic                              run_ended,
  output logic      [cprd_pkg::CNT_W-1:0]   run_length,
  output logic                              long_enough,
  output logic      [cprd_pkg::DUR_W-1:0]   short_pulse_duration
);
  import cprd_pkg::*;

  cfg_t                 cfg;
  cmd_t                 cmd;
  sts_t                 sts;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_duration      <= RST_MIN_DURATION;
      cfg.max_duration      <= RST_MAX_DURATION;
      cfg.max_run_length    <= RST_MAX_RUN_LENGTH;
      cfg.min_class_count   <= RST_MIN_CLASS_COUNT;
      cfg.min_signal_length <= RST_MIN_SIGNAL_LENGTH;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_DURATION:      cfg.min_duration      <= pwdata[DUR_W-1:0];
        REG_MAX_DURATION:      cfg.max_duration      <= pwdata[DUR_W-1:0];
        REG_MAX_RUN_LENGTH:    cfg.max_run_length    <= pwdata[CNT_W-1:0];
        REG_MIN_CLASS_COUNT:   cfg.min_class_count   <= pwdata[CNT_W-1:0];
        REG_MIN_SIGNAL_LENGTH: cfg.min_signal_length <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_DURATION:      prdata = DATA_W'(cfg.min_duration);
      REG_MAX_DURATION:      prdata = DATA_W'(cfg.max_duration);
      REG_MAX_RUN_LENGTH:    prdata = DATA_W'(cfg.max_run_length);
      REG_MIN_CLASS_COUNT:   prdata = DATA_W'(cfg.min_class_count);
      REG_MIN_SIGNAL_LENGTH: prdata = DATA_W'(cfg.min_signal_length);
      default:               prdata = '0;
    endcase
  end

  cprd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pulse_valid (pulse_valid),
    .pulse_stall (pulse_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  cprd_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cfg                  (cfg),
    .cmd                  (cmd),
    .sts                  (sts),
    .start_run            (start_run),
    .pulse_level          (pulse_level),
    .pulse_duration       (pulse_duration),
    .result_valid         (result_valid),
    .result_stall         (result_stall),
    .accepted             (accepted),
    .run_ended            (run_ended),
    .run_length           (run_length),
    .long_enough          (long_enough),
    .short_pulse_duration (short_pulse_duration)
  );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the coherent pulse run detector. Pulses go in on
// the pulse channel with bursts and random gaps while the result channel
// stalls on its own pattern. A local model of the duration classes predicts
// every result, and the bench compares it field by field. Directed pulses
// hit the duration limits, class matching, the run length limit and the
// degenerate register settings. Random coherent runs with noise then follow
// under several register settings. The APB registers are read back after each
// set of register writes.
// ---------------------------------------------------------------------------

module tb;
  import cprd_pkg::*;

  typedef struct packed {
    logic             accepted;
    logic             run_ended;
    logic [CNT_W-1:0] run_length;
    logic             long_enough;
    logic [DUR_W-1:0] short_pulse_duration;
  } pulse_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 pulse_valid = 1'b0;
  logic                 pulse_stall;
  logic                 start_run = 1'b0;
  logic                 pulse_level = 1'b0;
  logic [DUR_W-1:0]     pulse_duration = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 accepted;
  logic                 run_ended;
  logic [CNT_W-1:0]     run_length;
  logic                 long_enough;
  logic [DUR_W-1:0]     short_pulse_duration;

  coherent_pulse_run_detector dut (
    .clk                  (clk),
    .rst                  (rst),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .pulse_valid          (pulse_valid),
    .pulse_stall          (pulse_stall),
    .start_run            (start_run),
    .pulse_level          (pulse_level),
    .pulse_duration       (pulse_duration),
    .result_valid         (result_valid),
    .result_stall         (result_stall),
    .accepted             (accepted),
    .run_ended            (run_ended),
    .run_length           (run_length),
    .long_enough          (long_enough),
    .short_pulse_duration (short_pulse_duration)
  );

  // Model of the detector state and its registers.
  logic [DUR_W-1:0] cls_avg [SLOTS];
  logic [CNT_W-1:0] cls_members [SLOTS];
  logic [CNT_W-1:0] run_count;
  bit               run_halted;
  logic [DUR_W-1:0] lim_min_dur;
  logic [DUR_W-1:0] lim_max_dur;
  logic [CNT_W-1:0] lim_run_len;
  logic [CNT_W-1:0] lim_members;
  logic [CNT_W-1:0] lim_signal_len;

  pulse_result_t pending_results [$];
  int unsigned   mismatch_count = 0;
  int unsigned   examined_pulses = 0;
  int unsigned   burst_left = 0;
  bit            gapless = 1'b0;
  int unsigned   stall_mode = 1;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  function automatic void clear_classes();
    int s;
    for (s = 0; s < SLOTS; s++) begin
      cls_avg[s] = '0;
      cls_members[s] = '0;
    end
    run_count = '0;
    run_halted = 1'b0;
  endfunction

  function automatic bit place_in_class(input bit lvl, input logic [DUR_W-1:0] dur);
    int unsigned k, slot, a, n, diff;
    for (k = 0; k < NUM_CLASSES; k++) begin
      slot = lvl * NUM_CLASSES + k;
      a = cls_avg[slot];
      n = cls_members[slot];
      if (n == 0) begin
        cls_avg[slot] = dur;
        cls_members[slot] = CNT_W'(1);
        return 1'b1;
      end
      diff = (dur > a) ? dur - a : a - dur;
      if (diff < a / 8) begin
        cls_avg[slot] = DUR_W'((a * n + dur) / (n + 1));
        cls_members[slot] = (n + 1 > CNT_MAX) ? CNT_MAX : CNT_W'(n + 1);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [DUR_W-1:0] short_estimate();
    int unsigned best_lo, best_hi, k, a;
    best_lo = 0;
    best_hi = 0;
    for (k = 0; k < SLOTS; k++) begin
      a = cls_avg[k];
      if (a != 0 && cls_members[k] >= lim_members) begin
        if (k < NUM_CLASSES) begin
          if (best_lo == 0 || best_lo > a) best_lo = a;
        end else begin
          if (best_hi == 0 || best_hi > a) best_hi = a;
        end
      end
    end
    if (best_lo == 0) best_lo = best_hi;
    if (best_hi == 0) best_hi = best_lo;
    return DUR_W'((best_lo + best_hi) / 2);
  endfunction

  function automatic pulse_result_t predict_pulse(input bit st, input bit lvl,
                                                  input logic [DUR_W-1:0] dur);
    pulse_result_t r;
    bit took;
    took = 1'b0;
    if (st) clear_classes();
    if (!run_halted) begin
      if (run_count >= lim_run_len) begin
        run_halted = 1'b1;
      end else if (dur < lim_min_dur || dur > lim_max_dur) begin
        run_halted = 1'b1;
      end else if (!place_in_class(lvl, dur)) begin
        run_halted = 1'b1;
      end else begin
        took = 1'b1;
        run_count = run_count + 1'b1;
        if (run_count >= lim_run_len) run_halted = 1'b1;
      end
    end
    r.accepted = took;
    r.run_ended = run_halted;
    r.run_length = run_count;
    r.long_enough = (run_count > lim_signal_len);
    r.short_pulse_duration = short_estimate();
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_MIN_DURATION:      return DATA_W'(lim_min_dur);
      REG_MAX_DURATION:      return DATA_W'(lim_max_dur);
      REG_MAX_RUN_LENGTH:    return DATA_W'(lim_run_len);
      REG_MIN_CLASS_COUNT:   return DATA_W'(lim_members);
      REG_MIN_SIGNAL_LENGTH: return DATA_W'(lim_signal_len);
      default:               return '0;
    endcase
  endfunction

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MIN_DURATION:      lim_min_dur = val[DUR_W-1:0];
      REG_MAX_DURATION:      lim_max_dur = val[DUR_W-1:0];
      REG_MAX_RUN_LENGTH:    lim_run_len = val[CNT_W-1:0];
      REG_MIN_CLASS_COUNT:   lim_members = val[CNT_W-1:0];
      REG_MIN_SIGNAL_LENGTH: lim_signal_len = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic reg_check(input logic [REG_IDX_W-1:0] idx);
    logic [DATA_W-1:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== reg_value(idx))
      note_mismatch($sformatf("register %0d read: expected %0h, got %0h",
                              idx, reg_value(idx), got));
  endtask

  task automatic wait_idle();
    if (burst_left != 0) pulse_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_limits(input int unsigned min_dur, input int unsigned max_dur,
                            input int unsigned run_len, input int unsigned members,
                            input int unsigned signal_len);
    logic [REG_IDX_W-1:0] idx;
    wait_idle();
    reg_write(REG_MIN_DURATION, min_dur);
    reg_write(REG_MAX_DURATION, max_dur);
    reg_write(REG_MAX_RUN_LENGTH, run_len);
    reg_write(REG_MIN_CLASS_COUNT, members);
    reg_write(REG_MIN_SIGNAL_LENGTH, signal_len);
    for (idx = REG_MIN_DURATION; idx <= REG_MIN_SIGNAL_LENGTH; idx++) reg_check(idx);
  endtask

  // Sends one pulse request and records its expected result on acceptance.
  task automatic send_pulse(input bit st, input bit lvl, input logic [DUR_W-1:0] dur);
    bit was_halted;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = gapless ? 32'd1000000 : $urandom_range(1, 20);
    end
    pulse_valid <= 1'b1;
    start_run <= st;
    pulse_level <= lvl;
    pulse_duration <= dur;
    do @(posedge clk); while (pulse_stall);
    was_halted = run_halted;
    pending_results.push_back(predict_pulse(st, lvl, dur));
    if (st || !was_halted) examined_pulses++;
    burst_left--;
    if (burst_left == 0) pulse_valid <= 1'b0;
  endtask

  function automatic logic [DUR_W-1:0] near(input logic [DUR_W-1:0] base);
    int unsigned j, d;
    j = base / 32;
    d = base - j + $urandom_range(0, 2 * j);
    return (d > 65535) ? 16'hFFFF : DUR_W'(d);
  endfunction

  function automatic logic [DUR_W-1:0] pick_base();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return lim_min_dur;
    if (r < 10) return lim_max_dur;
    if (lim_min_dur > lim_max_dur) return DUR_W'($urandom);
    return DUR_W'($urandom_range(lim_min_dur, lim_max_dur));
  endfunction

  // Coherent runs with random class durations, jitter, noise and restarts.
  task automatic send_random_runs(input int unsigned target, input int unsigned max_len);
    logic [DUR_W-1:0] bases [2][4];
    int unsigned      stop_at, n_pulses, i, l, b, r;
    int unsigned      n_bases [2];
    bit               lvl, st;
    logic [DUR_W-1:0] dur;
    stop_at = examined_pulses + target;
    lvl = 1'b0;
    while (examined_pulses < stop_at) begin
      for (l = 0; l < 2; l++) begin
        n_bases[l] = $urandom_range(1, 3);
        for (b = 0; b < 4; b++) bases[l][b] = pick_base();
      end
      n_pulses = $urandom_range(3, max_len);
      for (i = 0; i < n_pulses; i++) begin
        if ($urandom_range(0, 4) == 0) lvl = 1'($urandom_range(0, 1));
        else lvl = ~lvl;
        r = $urandom_range(0, 99);
        if (r < 6) dur = DUR_W'($urandom);
        else if (r < 9) dur = near(bases[lvl][3]);
        else dur = near(bases[lvl][$urandom_range(0, n_bases[lvl] - 1)]);
        st = (i == 0) || ($urandom_range(0, 99) == 0);
        send_pulse(st, lvl, dur);
        if (run_halted && $urandom_range(0, 3) != 0) break;
      end
    end
  endtask

  always @(posedge clk) begin : stall_pattern
    int unsigned seg_left;
    bit          seg_stall;
    if (rst) begin
      result_stall <= 1'b0;
      seg_left = 0;
      seg_stall = 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, (stall_mode == 2) ? 40 : 6);
        seg_stall = (stall_mode != 0) &&
                    ($urandom_range(0, 99) < ((stall_mode == 2) ? 50 : 30));
      end else begin
        seg_left--;
      end
      result_stall <= seg_stall;
    end
  end

  always @(posedge clk) begin : check_results
    pulse_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result arrived with no pending expectation");
      end else begin
        want = pending_results.pop_front();
        if (accepted !== want.accepted || run_ended !== want.run_ended ||
            run_length !== want.run_length || long_enough !== want.long_enough ||
            short_pulse_duration !== want.short_pulse_duration)
          note_mismatch($sformatf(
            "result: expected %0b/%0b/%0d/%0b/%0d, got %0b/%0b/%0d/%0b/%0d",
            want.accepted, want.run_ended, want.run_length, want.long_enough,
            want.short_pulse_duration, accepted, run_ended, run_length, long_enough,
            short_pulse_duration));
      end
    end
  end

  task automatic test_register_defaults();
    logic [REG_IDX_W-1:0] idx;
    for (idx = REG_MIN_DURATION; idx <= REG_MIN_SIGNAL_LENGTH; idx++) reg_check(idx);
  endtask

  task automatic test_duration_limits();
    send_pulse(1'b1, 1'b0, 16'd29);
    send_pulse(1'b0, 1'b1, 16'd100);
    send_pulse(1'b1, 1'b1, 16'd30);
    send_pulse(1'b0, 1'b0, 16'd4000);
    send_pulse(1'b0, 1'b0, 16'd4001);
    send_pulse(1'b1, 1'b0, 16'hFFFF);
    send_pulse(1'b1, 1'b1, 16'd0);
  endtask

  task automatic test_class_matching();
    // A difference equal to one eighth of the average opens a new class.
    send_pulse(1'b1, 1'b0, 16'd800);
    send_pulse(1'b0, 1'b0, 16'd900);
    send_pulse(1'b0, 1'b0, 16'd899);
    send_pulse(1'b0, 1'b0, 16'd849);
    send_pulse(1'b0, 1'b1, 16'd2400);
    send_pulse(1'b0, 1'b1, 16'd2400);
    send_pulse(1'b0, 1'b1, 16'd2400);
    send_pulse(1'b0, 1'b0, 16'd3000);
    send_pulse(1'b0, 1'b0, 16'd100);
  endtask

  task automatic test_run_length_limit();
    set_limits(RST_MIN_DURATION, RST_MAX_DURATION, 3, RST_MIN_CLASS_COUNT, 1);
    send_pulse(1'b1, 1'b0, 16'd500);
    send_pulse(1'b0, 1'b1, 16'd500);
    send_pulse(1'b0, 1'b0, 16'd500);
    send_pulse(1'b0, 1'b0, 16'd500);
    set_limits(RST_MIN_DURATION, RST_MAX_DURATION, 0, RST_MIN_CLASS_COUNT, 1);
    send_pulse(1'b1, 1'b0, 16'd500);
  endtask

  task automatic test_crossed_limits();
    set_limits(100, 50, RST_MAX_RUN_LENGTH, 1, 0);
    send_pulse(1'b1, 1'b0, 16'd75);
    send_pulse(1'b1, 1'b1, 16'd100);
  endtask

  task automatic test_zero_average();
    set_limits(0, 0, 1, 0, 0);
    send_pulse(1'b1, 1'b0, 16'd0);
    set_limits(0, 65535, 1023, 0, 0);
    send_pulse(1'b1, 1'b0, 16'd0);
    send_pulse(1'b0, 1'b0, 16'd0);
    send_pulse(1'b0, 1'b1, 16'd5);
  endtask

  task automatic test_long_run();
    logic [DUR_W-1:0] bases [2][3];
    int unsigned      i;
    bit               lvl;
    bases = '{'{16'd100, 16'd300, 16'd900}, '{16'd150, 16'd450, 16'd1350}};
    set_limits(RST_MIN_DURATION, RST_MAX_DURATION, 1023, 2, 1000);
    stall_mode = 0;
    gapless = 1'b1;
    for (i = 0; i < 1026; i++) begin
      lvl = i[0];
      send_pulse(i == 0, lvl, near(bases[lvl][$urandom_range(0, 2)]));
    end
    send_pulse(1'b1, 1'b1, 16'd400);
    gapless = 1'b0;
  endtask

  task automatic test_random_runs();
    int unsigned p;
    set_limits(RST_MIN_DURATION, RST_MAX_DURATION, RST_MAX_RUN_LENGTH,
               RST_MIN_CLASS_COUNT, RST_MIN_SIGNAL_LENGTH);
    stall_mode = 1;
    send_random_runs(140, 60);
    set_limits(0, 65535, 1023, 1, 0);
    stall_mode = 0;
    gapless = 1'b1;
    send_random_runs(100, 80);
    gapless = 1'b0;
    set_limits($urandom_range(0, 200), $urandom_range(2000, 65535),
               $urandom_range(1, 40), 1023, 1023);
    stall_mode = 2;
    send_random_runs(100, 50);
    set_limits(65535, 65535, 1, 1, 0);
    send_random_runs(20, 10);
    for (p = 0; p < 4; p++) begin
      set_limits($urandom_range(0, 300), $urandom_range(0, 3) == 0 ? 65535 :
                 $urandom_range(200, 8000), $urandom_range(1, 1023),
                 $urandom_range(0, 6), $urandom_range(0, 60));
      stall_mode = $urandom_range(0, 2);
      gapless = ($urandom_range(0, 2) == 0);
      send_random_runs(30, 60);
    end
    gapless = 1'b0;
  endtask

  initial begin
    lim_min_dur = RST_MIN_DURATION;
    lim_max_dur = RST_MAX_DURATION;
    lim_run_len = RST_MAX_RUN_LENGTH;
    lim_members = RST_MIN_CLASS_COUNT;
    lim_signal_len = RST_MIN_SIGNAL_LENGTH;
    clear_classes();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults();
    test_duration_limits();
    test_class_matching();
    test_run_length_limit();
    test_crossed_limits();
    test_zero_average();
    test_long_run();
    test_random_runs();
    wait_idle();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
